FILE: rtl/lap_pkg.sv
// Shared constants, types and table functions of the LFO allpass phaser.
package lap_pkg;

  // Default sizes of the block.
  localparam int unsigned LAP_MAX_STAGES = 8;
  localparam int unsigned LAP_SAMPLE_BITS = 24;
  localparam int unsigned LAP_SINE_DEPTH = 256;
  localparam int unsigned LAP_COEF_DEPTH = 1024;

  // Width of a gain or coefficient operand of the shared multiplier (signed).
  localparam int unsigned GAIN_W = 18;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FREQ = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FREQ_SPAN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT = 3'd5;

  // Register limits and reset values.
  localparam logic [15:0] FEEDBACK_MAX = 16'd62259;
  localparam logic [16:0] MIX_MAX = 17'd65536;
  localparam logic [16:0] NYQ_CAP = 17'd32767;
  localparam logic [23:0] RST_PHASE_STEP = 24'd44739;
  localparam logic [14:0] RST_MIN_FREQ = 15'd273;
  localparam logic [14:0] RST_FREQ_SPAN = 15'd2458;
  localparam logic [15:0] RST_FEEDBACK = 16'd32768;
  localparam logic [16:0] RST_WET_MIX = 17'd32768;
  localparam int unsigned RST_STAGE_COUNT = 6;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_LFO,
    S_FC,
    S_COEF,
    S_FB,
    S_FBADD,
    S_STMUL,
    S_STADD,
    S_MIX1,
    S_MIX2,
    S_MIXSUM,
    S_OUT
  } lap_state_e;

  // Sine of ang/2^32 turns in Q1.16, from a quarter-wave polynomial in Q30.
  // Only ever evaluated on constants to build the tables.
  function automatic logic signed [GAIN_W-1:0] sin16(input logic [31:0] ang);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned v;
    logic [1:0] quad;
    quad = ang[31:30];
    r = longint'(ang[29:0]);
    if (quad[0]) begin
      r = 64'd1073741824 - r;
    end
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = 64'd1073741824 - x2 / 64'd72;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd42;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd20;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 64'd6;
    v = (x * t) >> 30;
    v = (v + 64'd8192) >> 14;
    if (v > 64'd65536) begin
      v = 64'd65536;
    end
    return quad[1] ? -GAIN_W'(v) : GAIN_W'(v);
  endfunction

  // Allpass coefficient (tan-1)/(tan+1) in signed Q1.16 for table entry j.
  function automatic logic signed [GAIN_W-1:0] coef_entry(input int unsigned j,
                                                          input int unsigned depth_log);
    logic [31:0] u;
    logic signed [GAIN_W-1:0] c;
    logic signed [GAIN_W-1:0] s;
    longint unsigned den;
    longint unsigned num;
    longint unsigned mag;
    longint unsigned rem;
    u = 32'(longint'(j) << (32 - depth_log));
    c = sin16(u + 32'h4000_0000);
    s = sin16(u);
    if (s < 0) begin
      s = '0;
    end
    den = 64'd65536 + longint'(s);
    num = longint'(c < 0 ? -c : c) << 16;
    // Rounded quotient by long division; it never needs more than 18 bits.
    rem = num + (den >> 1);
    mag = '0;
    for (int b = 17; b >= 0; b--) begin
      if (rem >= (den << b)) begin
        rem = rem - (den << b);
        mag = mag | (64'd1 << b);
      end
    end
    return (c > 0) ? -GAIN_W'(mag) : GAIN_W'(mag);
  endfunction

endpackage

FILE: rtl/lap_mul.sv
// Shared signed multiplier with a registered product.
module lap_mul #(
  parameter int unsigned AW = 25
) (
  input  logic                                  clk_i,
  input  logic signed [AW-1:0]                  a_i,
  input  logic signed [lap_pkg::GAIN_W-1:0]     b_i,
  output logic signed [AW+lap_pkg::GAIN_W-1:0]  p_o
);
  import lap_pkg::*;

  logic signed [AW+GAIN_W-1:0] p_q;

  // One product per cycle; the sequencer picks the operands.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

FILE: rtl/lap_rom.sv
// Constant sine and allpass coefficient tables of the phaser.
module lap_rom #(
  parameter int unsigned SINE_DEPTH = lap_pkg::LAP_SINE_DEPTH,
  parameter int unsigned COEF_DEPTH = lap_pkg::LAP_COEF_DEPTH
) (
  input  logic                                clk_i,
  input  logic [$clog2(SINE_DEPTH)-1:0]       sine_idx_i,
  output logic signed [lap_pkg::GAIN_W-1:0]   sine_o,
  input  logic [$clog2(COEF_DEPTH)-1:0]       coef_idx_i,
  output logic signed [lap_pkg::GAIN_W-1:0]   coef_o
);
  import lap_pkg::*;

  localparam int unsigned SLOG = $clog2(SINE_DEPTH);
  localparam int unsigned CLOG = $clog2(COEF_DEPTH);

  logic signed [GAIN_W-1:0] sine_rom [SINE_DEPTH];
  logic signed [GAIN_W-1:0] coef_rom [COEF_DEPTH];
  logic signed [GAIN_W-1:0] coef_q;

  // Table contents are folded to constants at elaboration.
  for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_sine
    assign sine_rom[g] = sin16(32'(longint'(g) << (32 - SLOG)));
  end

  for (genvar g = 0; g < COEF_DEPTH; g++) begin : g_coef
    assign coef_rom[g] = coef_entry(g, CLOG);
  end

  // The sine table is read directly; the larger coefficient table is registered.
  assign sine_o = sine_rom[sine_idx_i];

  always_ff @(posedge clk_i) begin
    coef_q <= coef_rom[coef_idx_i];
  end

  assign coef_o = coef_q;

endmodule

FILE: rtl/lfo_allpass_phaser_core.sv
// Top level of the LFO driven first-order allpass phaser.
//
//  Channel   Direction  Handshake                  Payload
//  s_axis    in         s_axis_tvalid/tready       tdata: sample_in
//  m_axis    out        m_axis_tvalid/tready       tdata: sample_out
//  cfg       in         cfg_we_i                   cfg_idx_i, cfg_data_i
//
// An accepted sample steps through the states LFO, FC, COEF, FB, FBADD, an
// STMUL/STADD pair per stage, MIX1, MIX2, MIXSUM and OUT; the one shared
// multiplier is used once per stage plus four times for sweep, feedback and
// blend. s_axis_tready is high only while the sequencer is idle, so no new
// sample is taken while one is in work. A finished sample waits in the output
// register while the next one is processed; the sequencer holds in OUT, before
// loading the output register, only while the previous one has not been taken.
// Reset clears the LFO phase, the stage history and all control state at once.
module lfo_allpass_phaser_core #(
  parameter int unsigned MAX_STAGES       = lap_pkg::LAP_MAX_STAGES,
  parameter int unsigned SAMPLE_BITS      = lap_pkg::LAP_SAMPLE_BITS,
  parameter int unsigned SINE_TABLE_DEPTH = lap_pkg::LAP_SINE_DEPTH,
  parameter int unsigned COEF_TABLE_DEPTH = lap_pkg::LAP_COEF_DEPTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: sample_in [SAMPLE_BITS-1:0], zero padding above
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: sample_out [SAMPLE_BITS-1:0], zero padding above
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_axis_tdata,
  input  logic                                 cfg_we_i,
  input  logic [lap_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [lap_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import lap_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned TDW = ((SB + 7) / 8) * 8;
  localparam int unsigned AW = SB + 1;
  localparam int unsigned PW = AW + GAIN_W;
  localparam int unsigned ACC_W = PW + 1;
  localparam int unsigned RW = ACC_W - 16;
  localparam int unsigned IW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int unsigned SCW = $clog2(MAX_STAGES + 1);
  localparam int unsigned SLOG = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned CLOG = $clog2(COEF_TABLE_DEPTH);
  localparam logic signed [RW-1:0] SAT_HI = {{(RW-SB+1){1'b0}}, {(SB-1){1'b1}}};
  localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

  // Saturate a wide intermediate to the sample range.
  function automatic logic signed [SB-1:0] sat_f(input logic signed [RW-1:0] v);
    logic signed [SB-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[SB-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[SB-1:0];
    end else begin
      r = v[SB-1:0];
    end
    return r;
  endfunction

  // Round a Q16 product to nearest, ties upward, by floor shift.
  function automatic logic signed [RW-1:0] rnd_f(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] t;
    t = (v + ACC_W'(32768)) >>> 16;
    return t[RW-1:0];
  endfunction

  lap_state_e state_q, state_d;

  // Configuration registers.
  logic [23:0]         phase_step_q;
  logic [14:0]         min_freq_q;
  logic [14:0]         freq_span_q;
  logic [15:0]         feedback_q;
  logic [16:0]         wet_mix_q;
  logic [SCW-1:0]      stage_count_q;

  // Processing state.
  logic [31:0]         phase_q;
  logic signed [SB-1:0] in_prev_q  [MAX_STAGES];
  logic signed [SB-1:0] out_prev_q [MAX_STAGES];
  logic signed [SB-1:0] x_q;
  logic signed [SB-1:0] y_q;
  logic signed [SB-1:0] res_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [IW-1:0]       idx_q;
  logic [CLOG-1:0]     coef_idx_q;
  logic                out_valid_q;
  logic [SB-1:0]       out_data_q;

  // Shared unit and table signals.
  logic signed [AW-1:0]     mul_a;
  logic signed [GAIN_W-1:0] mul_b;
  logic signed [PW-1:0]     prod;
  logic signed [GAIN_W-1:0] sine_val;
  logic signed [GAIN_W-1:0] coef_val;
  logic signed [GAIN_W:0]   lfo_sum;
  logic [16:0]              lfo;
  logic [16:0]              fc_sum;
  logic [14:0]              fc;
  logic [IW-1:0]            last_idx;
  logic [IW-1:0]            rd_idx;
  logic signed [SB-1:0]     out_rd;
  logic signed [SB-1:0]     in_rd;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [SB-1:0]     fb_y;
  logic signed [SB-1:0]     stage_y;
  logic signed [SB-1:0]     mix_y;
  logic                     out_free;
  logic                     last_stage;
  logic [31:0]              cfg_val;

  lap_mul #(.AW(AW)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  lap_rom #(
    .SINE_DEPTH (SINE_TABLE_DEPTH),
    .COEF_DEPTH (COEF_TABLE_DEPTH)
  ) u_rom (
    .clk_i      (clk_i),
    .sine_idx_i (phase_q[31 -: SLOG]),
    .sine_o     (sine_val),
    .coef_idx_i (coef_idx_q),
    .coef_o     (coef_val)
  );

  // LFO value and the swept centre frequency, capped below Nyquist.
  assign lfo_sum = (GAIN_W+1)'(65536) + (GAIN_W+1)'(sine_val);
  assign lfo = lfo_sum[17:1];
  assign fc_sum = 17'(min_freq_q) + 17'(prod[31:16]);
  assign fc = (fc_sum > NYQ_CAP) ? NYQ_CAP[14:0] : fc_sum[14:0];

  // Stage history read port: the last active stage for feedback, else the
  // stage being worked on.
  assign last_idx = IW'(stage_count_q - SCW'(1));
  assign rd_idx = (state_q == S_FB) ? last_idx : idx_q;
  assign out_rd = out_prev_q[rd_idx];
  assign in_rd = in_prev_q[rd_idx];
  assign last_stage = (idx_q == last_idx);

  // Post-multiply results.
  assign prod_ext = ACC_W'(prod);
  assign fb_y = sat_f(RW'(x_q) + rnd_f(prod_ext));
  assign stage_y = sat_f(rnd_f(prod_ext) + RW'(in_rd));
  assign mix_y = sat_f(rnd_f(acc_q + prod_ext));

  assign out_free = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and multiplier operand selection.
  always_comb begin
    state_d = state_q;
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_LFO;
        end
      end
      S_LFO: begin
        mul_a = AW'(freq_span_q);
        mul_b = GAIN_W'(lfo);
        state_d = S_FC;
      end
      S_FC: begin
        state_d = S_COEF;
      end
      S_COEF: begin
        state_d = S_FB;
      end
      S_FB: begin
        mul_a = AW'(out_rd);
        mul_b = GAIN_W'(feedback_q);
        state_d = S_FBADD;
      end
      S_FBADD: begin
        state_d = S_STMUL;
      end
      S_STMUL: begin
        mul_a = AW'(y_q) - AW'(out_rd);
        mul_b = coef_val;
        state_d = S_STADD;
      end
      S_STADD: begin
        state_d = last_stage ? S_MIX1 : S_STMUL;
      end
      S_MIX1: begin
        mul_a = AW'(x_q);
        mul_b = GAIN_W'(MIX_MAX - wet_mix_q);
        state_d = S_MIX2;
      end
      S_MIX2: begin
        mul_a = AW'(y_q);
        mul_b = GAIN_W'(wet_mix_q);
        state_d = S_MIXSUM;
      end
      S_MIXSUM: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Configuration writes, with the documented clamps.
  assign cfg_val = 32'(cfg_data_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= RST_PHASE_STEP;
      min_freq_q <= RST_MIN_FREQ;
      freq_span_q <= RST_FREQ_SPAN;
      feedback_q <= RST_FEEDBACK;
      wet_mix_q <= RST_WET_MIX;
      stage_count_q <= SCW'(RST_STAGE_COUNT);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_STEP: phase_step_q <= cfg_val[23:0];
        CFG_MIN_FREQ: min_freq_q <= cfg_val[14:0];
        CFG_FREQ_SPAN: freq_span_q <= cfg_val[14:0];
        CFG_FEEDBACK: begin
          feedback_q <= (cfg_val[15:0] > FEEDBACK_MAX) ? FEEDBACK_MAX : cfg_val[15:0];
        end
        CFG_WET_MIX: begin
          wet_mix_q <= (cfg_val[16:0] > MIX_MAX) ? MIX_MAX : cfg_val[16:0];
        end
        CFG_STAGE_COUNT: begin
          if (cfg_val[3:0] < 4'd2) begin
            stage_count_q <= SCW'(2);
          end else if (32'(cfg_val[3:0]) > MAX_STAGES) begin
            stage_count_q <= SCW'(MAX_STAGES);
          end else begin
            stage_count_q <= SCW'(cfg_val[3:0]);
          end
        end
        default: ;
      endcase
    end
  end

  // LFO phase, stage history and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      out_valid_q <= 1'b0;
      idx_q <= '0;
      for (int i = 0; i < MAX_STAGES; i++) begin
        in_prev_q[i] <= '0;
        out_prev_q[i] <= '0;
      end
    end else begin
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_FBADD: idx_q <= '0;
        S_STADD: begin
          in_prev_q[idx_q] <= y_q;
          out_prev_q[idx_q] <= stage_y;
          idx_q <= idx_q + IW'(1);
        end
        S_OUT: begin
          if (out_free) begin
            phase_q <= phase_q + 32'(phase_step_q);
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the working sample.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: x_q <= s_axis_tdata[SB-1:0];
      S_FC: coef_idx_q <= CLOG'(fc >> (15 - CLOG));
      S_FBADD: y_q <= fb_y;
      S_STADD: y_q <= stage_y;
      S_MIX2: acc_q <= prod_ext;
      S_MIXSUM: res_q <= mix_y;
      S_OUT: begin
        if (out_free) begin
          out_data_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata = TDW'(out_data_q);

endmodule

FILE: tb/lfo_allpass_phaser_core_test.sv
// Self-checking testbench of the LFO allpass phaser core, with its own bit-true predictor.
module lfo_allpass_phaser_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import lap_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 2 * LAP_MAX_STAGES + 11 + 16;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // tdata: sample_in [23:0]
  logic [23:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // tdata: sample_out [23:0]
  logic [23:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = CFG_PHASE_STEP;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  lfo_allpass_phaser_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Shadow copy of the registers and the filter history.
  logic [23:0] step_reg;
  logic [14:0] fmin_reg;
  logic [14:0] fspan_reg;
  logic [15:0] fb_reg;
  logic [16:0] mix_reg;
  int unsigned nstages;
  logic [31:0] lfo_acc;
  longint stage_x_hist[LAP_MAX_STAGES];
  longint stage_y_hist[LAP_MAX_STAGES];

  logic signed [23:0] expected_samples[$];
  bit failed = 1'b0;

  // Traffic shaping knobs, changed per phase.
  int unsigned gap_max = 0;
  int unsigned burst_left = 0;
  int unsigned stall_pct = 0;
  bit stall_periodic = 1'b0;
  int unsigned stall_tick = 0;

  // Quarter-wave polynomial sine in Q1.16 of ang/2^32 turns.
  function automatic longint sine_q16(input logic [31:0] ang);
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned v;
    r = {34'd0, ang[29:0]};
    if (ang[30]) r = 64'd1073741824 - r;
    x = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    t = 64'd1073741824 - x2 / 72;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    v = (((x * t) >> 30) + 64'd8192) >> 14;
    if (v > 64'd65536) v = 64'd65536;
    return ang[31] ? -longint'(v) : longint'(v);
  endfunction

  // Rounded Q0.16 product scaling, ties upward.
  function automatic longint rnd16(input longint v);
    return (v + 32768) >>> 16;
  endfunction

  function automatic longint clip24(input longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // Works out the output sample for one accepted input and updates the history.
  function automatic logic signed [23:0] phaser_sample(input logic signed [23:0] din);
    longint x;
    longint y;
    longint o;
    longint lfo;
    longint fc;
    longint c;
    longint s;
    longint unsigned den;
    longint unsigned mag;
    longint a;
    logic [31:0] u;
    x = longint'(din);
    lfo = (65536 + sine_q16({lfo_acc[31:24], 24'd0})) >>> 1;
    fc = longint'(fmin_reg) + ((lfo * longint'(fspan_reg)) >>> 16);
    if (fc > 32767) fc = 32767;
    u = 32'(fc >> 5) << 22;
    c = sine_q16(u + 32'h4000_0000);
    s = sine_q16(u);
    if (s < 0) s = 0;
    den = 64'(65536 + s);
    mag = ((64'(c < 0 ? -c : c) << 16) + den / 2) / den;
    a = (c > 0) ? -longint'(mag) : longint'(mag);
    y = clip24(x + rnd16(longint'(fb_reg) * stage_y_hist[nstages - 1]));
    for (int unsigned k = 0; k < nstages; k++) begin
      o = clip24(rnd16(a * (y - stage_y_hist[k])) + stage_x_hist[k]);
      stage_x_hist[k] = y;
      stage_y_hist[k] = o;
      y = o;
    end
    lfo_acc = lfo_acc + {8'd0, step_reg};
    return 24'(clip24(rnd16(x * (65536 - longint'(mix_reg)) + y * longint'(mix_reg))));
  endfunction

  // Compare every output transaction with the oldest expected sample.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $error("sample_out: unexpected output %0d", $signed(m_axis_tdata));
        failed = 1'b1;
      end else if (m_axis_tdata !== expected_samples[0]) begin
        $error("sample_out: expected %0d, actual %0d", expected_samples[0],
               $signed(m_axis_tdata));
        failed = 1'b1;
        void'(expected_samples.pop_front());
      end else begin
        void'(expected_samples.pop_front());
      end
    end
  end

  // Receiver back-pressure: random or periodic stalls.
  always @(negedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_periodic) m_axis_tready <= (stall_tick % 7) < 4;
    else if (stall_pct == 0) m_axis_tready <= 1'b1;
    else m_axis_tready <= $urandom_range(99) >= stall_pct;
  end

  // Offer one sample, honouring the burst and gap pattern of the sender.
  task automatic send_sample(input logic signed [23:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(30, 1);
      gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
      if (gap != 0) begin
        @(negedge clk_i);
        s_axis_tvalid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata = v;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_samples.push_back(phaser_sample(v));
  endtask

  // Let every result drain and the sequencer settle.
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait (expected_samples.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Register write while idle, mirrored in the predictor.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_PHASE_STEP: step_reg = val;
      CFG_MIN_FREQ: fmin_reg = val[14:0];
      CFG_FREQ_SPAN: fspan_reg = val[14:0];
      CFG_FEEDBACK: fb_reg = (val[15:0] > FEEDBACK_MAX) ? FEEDBACK_MAX : val[15:0];
      CFG_WET_MIX: mix_reg = (val[16:0] > MIX_MAX) ? MIX_MAX : val[16:0];
      CFG_STAGE_COUNT: begin
        nstages = val[3:0];
        if (nstages < 2) nstages = 2;
        if (nstages > LAP_MAX_STAGES) nstages = LAP_MAX_STAGES;
      end
      default: ;
    endcase
  endtask

  task automatic write_all(input logic [23:0] st, input logic [23:0] fmn, input logic [23:0] fsp,
                           input logic [23:0] fb, input logic [23:0] mx, input logic [23:0] ns);
    write_reg(CFG_PHASE_STEP, st);
    write_reg(CFG_MIN_FREQ, fmn);
    write_reg(CFG_FREQ_SPAN, fsp);
    write_reg(CFG_FEEDBACK, fb);
    write_reg(CFG_WET_MIX, mx);
    write_reg(CFG_STAGE_COUNT, ns);
  endtask

  function automatic logic signed [23:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) return 24'($urandom);
    if (pick < 8) return 24'($signed($urandom_range(8191)) - 4096);
    return pick[0] ? 24'h7FFFFF : 24'h800000;
  endfunction

  // Field extremes and history build-up under the reset settings.
  task automatic test_reset_defaults();
    logic signed [23:0] edge_vals[8];
    edge_vals = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'hFFFFFF,
                  24'h000001, 24'h555555, 24'hAAAAAA, 24'h7FFFFF};
    foreach (edge_vals[i]) send_sample(edge_vals[i]);
    wait_idle();
  endtask

  // Clamps of every register: out-of-range values, Nyquist cap, unused indexes.
  task automatic test_register_limits();
    write_reg(3'd6, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    write_all(24'hFFFFFF, 24'h7FFF, 24'h7FFF, 24'hFFFF, 24'h1FFFF, 24'hF);
    repeat (4) send_sample(24'h7FFFFF);
    repeat (3) send_sample(24'h800000);
    wait_idle();
    write_all(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
    repeat (3) send_sample(24'h800000);
    wait_idle();
    write_all(24'd1, 24'd16384, 24'd32767, 24'd62259, 24'd65536, 24'd1);
    repeat (4) send_sample(24'h7FFFFF);
    wait_idle();
  endtask

  // Random traffic over random and extreme register settings.
  task automatic test_random_sweeps();
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: write_all(24'hFFFFFF, 24'h7FFF, 24'h7FFF, 24'd62259, 24'd65536, 24'd8);
        1: write_all(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd2);
        default: write_all(24'($urandom), 24'($urandom_range(32767)),
                           24'($urandom_range(p[0] ? 4000 : 32767)),
                           24'($urandom_range(65535)), 24'($urandom_range(131071)),
                           24'($urandom_range(15)));
      endcase
      gap_max = (p % 3 == 0) ? 0 : $urandom_range(20);
      stall_pct = (p % 4 == 1) ? 0 : $urandom_range(60);
      stall_periodic = (p == 5);
      repeat (190) send_sample(random_sample());
      wait_idle();
    end
  endtask

  initial begin
    step_reg = RST_PHASE_STEP;
    fmin_reg = RST_MIN_FREQ;
    fspan_reg = RST_FREQ_SPAN;
    fb_reg = RST_FEEDBACK;
    mix_reg = RST_WET_MIX;
    nstages = RST_STAGE_COUNT;
    lfo_acc = '0;
    foreach (stage_x_hist[i]) begin
      stage_x_hist[i] = 0;
      stage_y_hist[i] = 0;
    end
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_register_limits();
    test_random_sweeps();
    if (!failed && expected_samples.size() == 0) begin
      $display("lfo_allpass_phaser_core verification clean");
    end else begin
      $display("lfo_allpass_phaser_core verification failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("lfo_allpass_phaser_core verification failed");
    $finish;
  end

endmodule
